>>> src/fifo_queue_with_key_removal_unit_macros.svh
// Assertion macros for the key removal queue.
// Used by the top level; depends on clk and rst_n in the including scope.
`ifndef FIFO_QUEUE_WITH_KEY_REMOVAL_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_REMOVAL_UNIT_MACROS_SVH

// Condition holds in every cycle outside reset.
`define FQKR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FQKR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fqkr_pkg.sv
// Types and codes shared by the key removal queue.
// No dependencies.
`default_nettype none

package fqkr_pkg;

    localparam int unsigned FRAME_W = 16;

    typedef enum logic [1:0]
    {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_REM = 2'd2,
        FUNC_NOP = 2'd3
    } func_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [7:0]  class_mark;
        logic [7:0]  ref_mark;
        logic [15:0] frame;
        logic [15:0] io;
        logic [15:0] cpu;
        logic [7:0]  proc;
    } rec_t;

    typedef struct packed
    {
        logic               enq;
        logic               deq;
        logic               rem;
        logic [FRAME_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/fqkr_cell.sv
// One queue slot: a record, its valid bit and the key compare.
// Depends on fqkr_pkg.
`default_nettype none

module fqkr_cell
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire fqkr_pkg::cell_ctrl_t ctrl,
    input  wire fqkr_pkg::rec_t      new_rec,
    input  wire                      left_valid,
    input  wire fqkr_pkg::rec_t      right_rec,
    input  wire                      right_valid,
    input  wire                      hit_in,
    output logic                     hit_out,
    output fqkr_pkg::rec_t           rec,
    output logic                     valid
);
    import fqkr_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic valid_reg;
    logic valid_next;
    logic match;
    logic load;
    logic shift;

    assign match   = valid_reg && (rec_reg.frame == ctrl.key);
    assign hit_out = hit_in || match;
    assign load    = ctrl.enq && !valid_reg && left_valid;
    assign shift   = ctrl.deq || (ctrl.rem && hit_out);

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (load)
        begin
            rec_next   = new_rec;
            valid_next = 1'b1;
        end
        else if (shift)
        begin
            rec_next   = right_rec;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

>>> src/fifo_queue_with_key_removal_unit.sv
// Result words are registered in the cycle after their input words are accepted.
// One word per cycle unless m_tready stalls; the first-match search ripples one gate per cell.
// Reset clears the valid bits, the record count and the output register's valid flag.
// Record storage in the cells is not reset.
// Top level of the key removal queue; depends on fqkr_pkg, fqkr_cell and the macro header.
`default_nettype none

module fifo_queue_with_key_removal_unit
#(
    parameter int unsigned QUEUE_DEPTH = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // process_index, cpu_time, io_time, frame_number, ref_mark, class_mark, search_frame
    input  wire  [87:0] s_tdata,
    // func
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // out_process, out_cpu, out_io, out_frame, out_ref, out_class, occupancy, zero fill
    output logic [79:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    import fqkr_pkg::*;

    `include "fifo_queue_with_key_removal_unit_macros.svh"

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    func_t            func;
    logic             accept;
    cell_ctrl_t       ctrl;
    rec_t             new_rec;
    rec_t             cell_rec [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH:0]   hit;
    logic             full;
    logic             empty;
    logic             found;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    status_t          status;
    rec_t             out_rec;
    logic             out_valid_reg;
    logic [79:0]      out_data_reg;
    logic [79:0]      out_data_next;
    logic [1:0]       out_status_reg;

    assign func     = func_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign new_rec.proc       = s_tdata[7:0];
    assign new_rec.cpu        = s_tdata[23:8];
    assign new_rec.io         = s_tdata[39:24];
    assign new_rec.frame      = s_tdata[55:40];
    assign new_rec.ref_mark   = s_tdata[63:56];
    assign new_rec.class_mark = s_tdata[71:64];

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign ctrl.enq = accept && (func == FUNC_ENQ);
    assign ctrl.deq = accept && (func == FUNC_DEQ);
    assign ctrl.rem = accept && (func == FUNC_REM);
    assign ctrl.key = s_tdata[87:72];

    assign hit[0] = 1'b0;
    assign found  = hit[QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rec_t right_rec;
        logic right_valid;
        logic left_valid;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_rec   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid
            assign right_rec   = cell_rec[i+1];
            assign right_valid = cell_valid[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_valid = cell_valid[i-1];
        end

        fqkr_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_rec     (new_rec),
            .left_valid  (left_valid),
            .right_rec   (right_rec),
            .right_valid (right_valid),
            .hit_in      (hit[i]),
            .hit_out     (hit[i+1]),
            .rec         (cell_rec[i]),
            .valid       (cell_valid[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        out_rec    = '0;
        case (func)
            FUNC_ENQ:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_DEQ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    out_rec    = cell_rec[0];
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_REM:
            begin
                if (found)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status = ST_EMPTY;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[7:0]   = out_rec.proc;
        out_data_next[23:8]  = out_rec.cpu;
        out_data_next[39:24] = out_rec.io;
        out_data_next[55:40] = out_rec.frame;
        out_data_next[63:56] = out_rec.ref_mark;
        out_data_next[71:64] = out_rec.class_mark;
        out_data_next[76:72] = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `FQKR_ASSERT_ALWAYS(a_valid_packed,
        ((cell_valid + QUEUE_DEPTH'(1)) & cell_valid) == '0,
        "Valid cells are not packed toward the head.")
    `FQKR_ASSERT_ALWAYS(a_count_match,
        count_reg == CW'($countones(cell_valid)),
        "Record count disagrees with the valid cells.")
    `FQKR_ASSERT_NEXT(a_enq_grows, ctrl.enq && !full,
        count_reg == $past(count_reg) + CW'(1),
        "Accepted enqueue did not grow the queue.")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the key removal queue: random and directed words through the streams.
// Depends on fqkr_pkg and fifo_queue_with_key_removal_unit; a scoreboard class predicts results.
`timescale 1ns / 100ps

import fqkr_pkg::*;

class record_queue_model;
    typedef struct
    {
        status_t    status;
        rec_t       rec;
        logic [4:0] occupancy;
    } reply_t;

    int unsigned depth;
    rec_t        held[$];
    reply_t      replies_due[$];
    int          mismatches;
    int          checked;
    int          full_drops;
    int          empty_reads;
    int          key_hits;
    int          key_misses;

    function new(int unsigned queue_depth);
        depth = queue_depth;
        mismatches = 0;
        checked = 0;
        full_drops = 0;
        empty_reads = 0;
        key_hits = 0;
        key_misses = 0;
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

    function logic [15:0] held_frame();
        if (held.size() == 0)
        begin
            return 16'($urandom);
        end
        return held[$urandom_range(0, held.size() - 1)].frame;
    endfunction

    function void note_request(func_t op, rec_t rec, logic [15:0] key);
        reply_t r;
        int     hit;
        r.status = ST_OK;
        r.rec = '0;
        hit = -1;
        case (op)
            FUNC_ENQ:
            begin
                if (held.size() >= depth)
                begin
                    r.status = ST_FULL;
                    full_drops++;
                end
                else
                begin
                    held.push_back(rec);
                end
            end
            FUNC_DEQ:
            begin
                if (held.size() == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_reads++;
                end
                else
                begin
                    r.rec = held.pop_front();
                end
            end
            FUNC_REM:
            begin
                foreach (held[i])
                begin
                    if (hit < 0 && held[i].frame == key)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    r.status = ST_EMPTY;
                    key_misses++;
                end
                else
                begin
                    held.delete(hit);
                    key_hits++;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = 5'(held.size());
        replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         name, checked, want, got);
            end
        end
    endfunction

    function void check_reply(logic [1:0] status, logic [79:0] data);
        reply_t r;
        rec_t   got;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result word: status %h data %h", status, data);
            end
            return;
        end
        r = replies_due.pop_front();
        got = data[71:0];
        compare_field("status", r.status, status);
        compare_field("out_process", r.rec.proc, got.proc);
        compare_field("out_cpu", r.rec.cpu, got.cpu);
        compare_field("out_io", r.rec.io, got.io);
        compare_field("out_frame", r.rec.frame, got.frame);
        compare_field("out_ref", r.rec.ref_mark, got.ref_mark);
        compare_field("out_class", r.rec.class_mark, got.class_mark);
        compare_field("occupancy", r.occupancy, data[76:72]);
        compare_field("fill", 16'd0, data[79:77]);
        checked++;
    endfunction
endclass

module testbench;
    localparam int unsigned DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_WORDS = 1030;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [79:0] m_tdata;
    wire  [1:0]  m_tuser;

    record_queue_model model = new(DEPTH);
    int unsigned       sent_count = 0;
    int unsigned       cycle_count = 0;
    bit                calm = 1'b0;
    bit                long_hold_done = 1'b0;
    int unsigned       stall_left = 0;

    fifo_queue_with_key_removal_unit #(.QUEUE_DEPTH(DEPTH)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input func_t op, input rec_t rec, input logic [15:0] key);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {key, rec};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        model.note_request(op, rec, key);
        sent_count++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic rec_t make_rec(logic [7:0] proc, logic [15:0] frame);
        rec_t r;
        r = 72'({$urandom, $urandom, $urandom});
        r.proc = proc;
        r.frame = frame;
        return r;
    endfunction

    function automatic logic [15:0] pool_frame();
        if ($urandom_range(0, 9) == 0)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 5));
    endfunction

    task automatic run_directed();
        rec_t last;
        send_word(FUNC_DEQ, '0, 16'h0000);
        send_word(FUNC_REM, '0, 16'hFFFF);
        send_word(FUNC_NOP, '1, 16'h0000);
        send_word(FUNC_ENQ, '0, 16'hFFFF);
        send_word(FUNC_ENQ, '1, 16'h0000);
        for (int i = 2; i < DEPTH; i++)
        begin
            send_word(FUNC_ENQ, make_rec(8'(i), 16'h0100 + 16'(i)), 16'(i));
        end
        send_word(FUNC_ENQ, make_rec(8'hAA, 16'h5555), 16'h0000);
        // The head holds frame zero and the tail frame 16'h0100 + (DEPTH - 1).
        send_word(FUNC_REM, make_rec(8'h11, 16'h0001), 16'h0000);
        send_word(FUNC_REM, '0, 16'h0100 + 16'(DEPTH - 1));
        send_word(FUNC_REM, '0, 16'h1234);
        send_word(FUNC_DEQ, make_rec(8'h22, 16'h2222), 16'h0100);
        last = '1;
        send_word(FUNC_REM, last, 16'hFFFF);
    endtask

    task automatic run_random(input int unsigned count);
        func_t       op;
        rec_t        rec;
        logic [15:0] key;
        int unsigned roll;
        int unsigned enq_pct;
        for (int unsigned n = 0; n < count; n++)
        begin
            calm = (n + 120 >= count);
            case ((n / 48) % 4)
                0:       enq_pct = 65;
                2:       enq_pct = 20;
                default: enq_pct = 40;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                op = FUNC_NOP;
            end
            else if (roll < 3 + enq_pct)
            begin
                op = FUNC_ENQ;
            end
            else if (roll < 3 + enq_pct + (97 - enq_pct) / 2)
            begin
                op = FUNC_DEQ;
            end
            else
            begin
                op = FUNC_REM;
            end
            rec = 72'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 99) < 60)
            begin
                rec.frame = pool_frame();
            end
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                key = model.held_frame();
            end
            else if (roll < 75)
            begin
                key = pool_frame();
            end
            else
            begin
                key = 16'($urandom);
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(1, 3));
            end
            send_word(op, rec, key);
        end
    endtask

    // Result side: checks every accepted word and drives the stall pattern.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                model.check_reply(m_tuser, m_tdata);
            end
            if (!long_hold_done && sent_count >= 400)
            begin
                long_hold_done = 1'b1;
                stall_left = 120;
            end
            if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_WORDS);
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        $display("summary: %0d words sent, %0d results checked, %0d mismatches",
                 sent_count, model.checked, model.mismatches);
        $display("summary: %0d full drops, %0d empty dequeues, %0d keys found, %0d keys missed",
                 model.full_drops, model.empty_reads, model.key_hits, model.key_misses);
        if (model.mismatches == 0 && model.pending() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/fqkr_pkg.sv
src/fqkr_cell.sv
src/fifo_queue_with_key_removal_unit.sv
tb/testbench.sv
